[sv/far_pkg.sv]
// Package for the fraction add-and-reduce block: types, commands and status
// shared by the controller, the datapath and the top level. No dependencies.

package far_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_CHECK,
        ST_GCD,
        ST_DIVN_LD,
        ST_DIVN,
        ST_DIVD_LD,
        ST_DIVD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_N1D2,
        MUL_N2D1,
        MUL_D1D2
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     keep_p1;
        logic     sum_en;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_load;
        logic     div_sel_den;
        logic     div_step;
        logic     keep_qnum;
        logic     out_zero;
        logic     out_result;
    } t_cmd;

    typedef struct packed {
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage

[sv/far_ctrl.sv]
// Controller for the fraction add-and-reduce block: sequences multiply, gcd
// and the two divisions. Depends on far_pkg.

module far_ctrl import far_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_N1D2;
        o_busy  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N1D2;
                n_state       = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N2D1;
                o_cmd.keep_p1 = 1'b1;
                n_state       = ST_MUL_C;
            end
            ST_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D1D2;
                o_cmd.sum_en  = 1'b1;
                n_state       = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.gcd_init = 1'b1;
                if (i_status.num_zero) begin
                    o_cmd.out_zero = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done) begin
                    n_state = ST_DIVN_LD;
                end
            end
            ST_DIVN_LD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIVN;
            end
            ST_DIVN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DIVD_LD;
                end
            end
            ST_DIVD_LD: begin
                o_cmd.div_load    = 1'b1;
                o_cmd.div_sel_den = 1'b1;
                o_cmd.keep_qnum   = 1'b1;
                n_state           = ST_DIVD;
            end
            ST_DIVD: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_cmd.out_result = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/far_dp.sv]
// Datapath for the fraction add-and-reduce block: shared multiplier, binary
// gcd unit, restoring divider and output registers. Depends on far_pkg.

module far_dp import far_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [OPERAND_WIDTH-1:0]     i_n1,
    input  logic [OPERAND_WIDTH-1:0]     i_d1,
    input  logic [OPERAND_WIDTH-1:0]     i_n2,
    input  logic [OPERAND_WIDTH-1:0]     i_d2,
    output t_status                      o_status,
    output logic                         o_valid,
    output logic [2*OPERAND_WIDTH:0]     o_num,
    output logic [2*OPERAND_WIDTH-1:0]   o_den
);

    localparam int W  = OPERAND_WIDTH;
    localparam int NB = 2 * W + 1;             // numerator / gcd width
    localparam int KW = $clog2(NB + 1);        // shared power-of-two count
    localparam int CW = $clog2(NB);            // divider step count

    logic [W-1:0]    r_n1, r_d1, r_n2, r_d2;
    logic [2*W-1:0]  r_prod, r_p1, r_den;
    logic [NB-1:0]   r_num, r_a, r_b, r_g, r_rem, r_quo, r_qnum;
    logic [KW-1:0]   r_k;
    logic [CW-1:0]   r_cnt;
    logic            r_o_valid;
    logic [NB-1:0]   r_o_num;
    logic [2*W-1:0]  r_o_den;

    logic [W-1:0]    mul_a, mul_b;
    logic [NB:0]     rem_sh;
    logic            div_ge;
    logic [NB-1:0]   rem_sub;

    // multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_N1D2: begin
                mul_a = r_n1;
                mul_b = r_d2;
            end
            MUL_N2D1: begin
                mul_a = r_n2;
                mul_b = r_d1;
            end
            MUL_D1D2: begin
                mul_a = r_d1;
                mul_b = r_d2;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // restoring divider step
    assign rem_sh  = {r_rem, r_quo[NB-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_g});
    assign rem_sub = NB'(rem_sh - {1'b0, r_g});

    assign o_status.num_zero = (r_num == '0);
    assign o_status.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_status.div_done = (r_cnt == CW'(NB - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n1 <= i_n1;
            r_d1 <= i_d1;
            r_n2 <= i_n2;
            r_d2 <= i_d2;
        end
        if (i_cmd.mul_en) begin
            r_prod <= (2*W)'(mul_a) * (2*W)'(mul_b);
        end
        if (i_cmd.keep_p1) begin
            r_p1 <= r_prod;
        end
        if (i_cmd.sum_en) begin
            r_num <= {1'b0, r_p1} + {1'b0, r_prod};
        end
        if (i_cmd.gcd_init) begin
            r_den <= r_prod;
            r_a   <= r_num;
            r_b   <= {1'b0, r_prod};
            r_k   <= '0;
        end
        // Stein step; a zero operand ends the search with the other one
        if (i_cmd.gcd_step) begin
            if (r_a == '0) begin
                r_g <= r_b << r_k;
            end else if (r_b == '0) begin
                r_g <= r_a << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_cnt <= '0;
            r_quo <= i_cmd.div_sel_den ? {1'b0, r_den} : r_num;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CW'(1);
            if (div_ge) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[NB-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[NB-1:0];
                r_quo <= {r_quo[NB-2:0], 1'b0};
            end
        end
        if (i_cmd.keep_qnum) begin
            r_qnum <= r_quo;
        end
        if (i_cmd.out_zero) begin
            r_o_num <= '0;
            r_o_den <= (2*W)'(1);
        end else if (i_cmd.out_result) begin
            r_o_num <= r_qnum;
            r_o_den <= r_quo[2*W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.out_zero || i_cmd.out_result;
        end
    end

    assign o_valid = r_o_valid;
    assign o_num   = r_o_num;
    assign o_den   = r_o_den;

endmodule

[sv/fraction_add_and_reduce_top.sv]
// Top level of the fraction add-and-reduce block: controller plus datapath.
// Depends on far_pkg, far_ctrl and far_dp.
//
// Adds n1/d1 + n2/d2 and returns the sum in lowest terms. A transaction is
// taken on a rising edge with start high and busy low; busy then stays high
// until the result has been loaded into the output registers. Each result
// appears on o_sum_numerator / o_sum_denominator for exactly one cycle with
// o_valid high, and the receiver cannot stall it, so it must take it then.
// A zero sum comes back as 0/1 with o_valid high after the three multiply
// states and the check state. Otherwise the block runs a single shared
// W x W multiplier in three steps (n1*d2, n2*d1, d1*d2), a check state, a
// binary gcd that retires one shift or one subtract per cycle until one
// operand is zero, then two restoring divisions of 2W+1 quotient bits each,
// each after a load state, and an output state. A zero denominator (outside
// the legal range) returns 1/0, or 0/1 when the numerator sum is zero.
// busy drops in the cycle that o_valid rises, so the next start may be
// issued while a result is on the output.

module fraction_add_and_reduce_top import far_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OPERAND_WIDTH-1:0]     i_first_numerator,
    input  logic [OPERAND_WIDTH-1:0]     i_first_denominator,
    input  logic [OPERAND_WIDTH-1:0]     i_second_numerator,
    input  logic [OPERAND_WIDTH-1:0]     i_second_denominator,
    output logic                         o_valid,
    output logic [2*OPERAND_WIDTH:0]     o_sum_numerator,
    output logic [2*OPERAND_WIDTH-1:0]   o_sum_denominator
);

    t_cmd    cmd;
    t_status status;

    // sequencing: one transaction in flight at a time
    far_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // arithmetic and result registers
    far_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_n1     (i_first_numerator),
        .i_d1     (i_first_denominator),
        .i_n2     (i_second_numerator),
        .i_d2     (i_second_denominator),
        .o_status (status),
        .o_valid  (o_valid),
        .o_num    (o_sum_numerator),
        .o_den    (o_sum_denominator)
    );

endmodule

[tb/fraction_add_and_reduce_top_tb.sv]
// Self-checking testbench for fraction_add_and_reduce_top: directed and random
// fraction pairs, expected sums worked out in lowest terms alongside the block.
// Depends on far_pkg and the RTL of fraction_add_and_reduce_top.

module fraction_add_and_reduce_top_tb;

    localparam int W     = far_pkg::OPERAND_WIDTH_DEF;
    localparam int NUM_W = 2 * W + 1;
    localparam int DEN_W = 2 * W;

    // Random part of the run; the directed part comes on top of it.
    localparam int RANDOM_ITEMS = 500;
    // Watchdog limit for the whole run, set well above its worst case.
    localparam int CYCLE_LIMIT  = 600000;
    // Quiet time after the last result; longer than one full transaction.
    localparam int TAIL_CYCLES  = 250;

    // One pending transaction: two fractions, the idle cycles the sender
    // spends before raising start, and whether it first waits for all
    // outstanding sums to come back.
    typedef struct {
        logic [W-1:0] n1;
        logic [W-1:0] d1;
        logic [W-1:0] n2;
        logic [W-1:0] d2;
        int unsigned  gap;
        bit           drain;
    } t_operand_set;

    typedef struct {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_reduced_sum;

    logic             i_clk  = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start  = 1'b0;
    logic             busy;
    logic [W-1:0]     i_first_numerator    = '0;
    logic [W-1:0]     i_first_denominator  = '1;
    logic [W-1:0]     i_second_numerator   = '0;
    logic [W-1:0]     i_second_denominator = '1;
    logic             o_valid;
    logic [NUM_W-1:0] o_sum_numerator;
    logic [DEN_W-1:0] o_sum_denominator;

    t_operand_set operand_queue[$];
    t_reduced_sum sums_awaited[$];

    // sums_issued and idle_count belong to the driver, sums_done to the
    // monitor; the ending sequence reads them on the falling edge only.
    int unsigned sums_issued = 0;
    int unsigned sums_done   = 0;
    int unsigned idle_count  = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    fraction_add_and_reduce_top #(
        .OPERAND_WIDTH(W)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_first_numerator   (i_first_numerator),
        .i_first_denominator (i_first_denominator),
        .i_second_numerator  (i_second_numerator),
        .i_second_denominator(i_second_denominator),
        .o_valid             (o_valid),
        .o_sum_numerator     (o_sum_numerator),
        .o_sum_denominator   (o_sum_denominator)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // n1/d1 + n2/d2 in lowest terms. Euclid's algorithm on the unreduced
    // numerator and denominator; a zero sum comes out as 0/1.
    function automatic t_reduced_sum reduce_fraction_sum(
        logic [W-1:0] n1, logic [W-1:0] d1, logic [W-1:0] n2, logic [W-1:0] d2
    );
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  r;
        t_reduced_sum res;
        num = 64'(n1) * 64'(d2) + 64'(n2) * 64'(d1);
        den = 64'(d1) * 64'(d2);
        if (num == 64'd0) begin
            res.num = '0;
            res.den = DEN_W'(1);
            return res;
        end
        a = num;
        b = den;
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        // a zero divisor only arises with both terms zero, excluded above
        if (a == 64'd0)
            a = 64'd1;
        res.num = NUM_W'(num / a);
        res.den = DEN_W'(den / a);
        return res;
    endfunction

    // Operand value drawn from a mix of shapes: tiny, byte-sized, powers of
    // two, all ones, zero and full range. Denominators are kept nonzero.
    function automatic logic [W-1:0] pick_operand(bit is_den);
        logic [W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = W'($urandom_range(0, 15));
            1: v = W'($urandom_range(0, 255));
            2: v = W'(1) << $urandom_range(0, W - 1);
            3: v = '1;
            4: v = is_den ? W'(1) : '0;
            default: v = W'($urandom());
        endcase
        if (is_den && v == '0)
            v = W'(1);
        return v;
    endfunction

    task automatic queue_operands(logic [W-1:0] n1, logic [W-1:0] d1,
                                  logic [W-1:0] n2, logic [W-1:0] d2,
                                  int unsigned gap, bit drain);
        t_operand_set s;
        s.n1    = n1;
        s.d1    = d1;
        s.n2    = n2;
        s.d2    = d2;
        s.gap   = gap;
        s.drain = drain;
        operand_queue.push_back(s);
    endtask

    // Driver. A transaction is taken at an edge with start high and busy low.
    // start is worked out once per edge and written by one assignment, so a
    // back-to-back launch never drops and raises it in the same step. The
    // gap is counted in cycles with busy low; a gap of zero raises start at
    // once, often while the block is still busy.
    always @(posedge i_clk) begin
        t_operand_set nxt;
        bit           start_nxt;
        bit           launch_ok;
        if (!i_rst_n) begin
            start      <= 1'b0;
            idle_count  = 0;
        end else begin
            start_nxt = start;
            if (start && !busy) begin
                sums_awaited.push_back(reduce_fraction_sum(
                    i_first_numerator, i_first_denominator,
                    i_second_numerator, i_second_denominator));
                sums_issued++;
                start_nxt  = 1'b0;
                idle_count = 0;
            end
            if (!start_nxt && operand_queue.size() != 0) begin
                // sums_done is the monitor's count as of before this edge
                launch_ok = (idle_count >= operand_queue[0].gap) &&
                            (!operand_queue[0].drain || sums_issued == sums_done);
                if (launch_ok) begin
                    nxt = operand_queue.pop_front();
                    i_first_numerator    <= nxt.n1;
                    i_first_denominator  <= nxt.d1;
                    i_second_numerator   <= nxt.n2;
                    i_second_denominator <= nxt.d2;
                    start_nxt = 1'b1;
                end else if (!busy) begin
                    idle_count++;
                end
            end
            start <= start_nxt;
        end
    end

    // Monitor. A result is on the ports for one cycle only and is taken at
    // the edge that ends it; it is checked against the oldest awaited sum.
    always @(posedge i_clk) begin
        t_reduced_sum want;
        if (i_rst_n && o_valid) begin
            if (sums_awaited.size() == 0) begin
                $error("unexpected result %0d/%0d with no transaction pending",
                       o_sum_numerator, o_sum_denominator);
                fail_count++;
            end else begin
                want = sums_awaited.pop_front();
                if (o_sum_numerator !== want.num) begin
                    $error("sum_numerator: expected %0d, got %0d",
                           want.num, o_sum_numerator);
                    fail_count++;
                end
                if (o_sum_denominator !== want.den) begin
                    $error("sum_denominator: expected %0d, got %0d",
                           want.den, o_sum_denominator);
                    fail_count++;
                end
            end
            sums_done <= sums_done + 1;
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] n1;
        logic [W-1:0] d1;
        logic [W-1:0] n2;
        logic [W-1:0] d2;
        int unsigned  gap;
        bit           no_idle;

        // Directed part: field extremes, zero sums, a divisor of one,
        // large coprime terms that set the top numerator bit, and sums that
        // reduce heavily. One transaction waits for the pipe to empty.
        queue_operands(16'd0,     16'd1,     16'd0,     16'd1,     0, 1'b0);
        queue_operands(16'd0,     16'hFFFF,  16'd0,     16'hFFFF,  0, 1'b0);
        queue_operands(16'd0,     16'd7,     16'd0,     16'd3,     2, 1'b0);
        queue_operands(16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  0, 1'b0);
        queue_operands(16'hFFFF,  16'd1,     16'hFFFF,  16'd1,     1, 1'b0);
        queue_operands(16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFE,  0, 1'b0);
        queue_operands(16'hFFFF,  16'd1,     16'hFFFF,  16'hFFFE,  3, 1'b0);
        queue_operands(16'd1,     16'hFFFF,  16'd1,     16'hFFFE,  0, 1'b0);
        queue_operands(16'd1,     16'hFFFF,  16'd1,     16'hFFFF,  0, 1'b0);
        queue_operands(16'd65521, 16'd65519, 16'd65519, 16'd65521, 0, 1'b0);
        queue_operands(16'd1,     16'd2,     16'd1,     16'd2,     0, 1'b1);
        queue_operands(16'd1,     16'd3,     16'd1,     16'd6,     1, 1'b0);
        queue_operands(16'd0,     16'd7,     16'd5,     16'd7,     0, 1'b0);
        queue_operands(16'd3,     16'd1,     16'd0,     16'hFFFF,  0, 1'b0);
        queue_operands(16'd12345, 16'd54321, 16'd0,     16'd1,     2, 1'b0);
        queue_operands(16'd1,     16'h8000,  16'd1,     16'h8000,  0, 1'b0);
        queue_operands(16'h8000,  16'd1,     16'h8000,  16'd1,     0, 1'b0);
        queue_operands(16'd1,     16'd1,     16'd1,     16'd1,     0, 1'b0);
        queue_operands(16'hAAAA,  16'h5555,  16'h5555,  16'hAAAA,  1, 1'b0);
        queue_operands(16'h5555,  16'hAAAA,  16'hAAAA,  16'h5555,  0, 1'b0);
        queue_operands(16'd2,     16'd3,     16'd4,     16'd6,     0, 1'b0);

        // Random part. Some operand pairs are tied together so that the
        // gcd has real work to do; every so often a stretch runs with no
        // idle cycles at all.
        no_idle = 1'b0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            n1 = pick_operand(1'b0);
            d1 = pick_operand(1'b1);
            n2 = pick_operand(1'b0);
            d2 = pick_operand(1'b1);
            case ($urandom_range(0, 9))
                0: d2 = d1;
                1: begin
                    n1 = '0;
                    n2 = '0;
                end
                2: begin
                    n2 = n1;
                    d2 = d1;
                end
                3: d2 = W'(d1 * $urandom_range(2, 9));
                4: n2 = W'(n1 * $urandom_range(1, 5));
                default: ;
            endcase
            if (d2 == '0)
                d2 = W'(1);
            gap = no_idle ? 0 : $urandom_range(0, 3);
            queue_operands(n1, d1, n2, d2, gap, ($urandom_range(0, 39) == 0));
        end

        // Hold reset, then release it on a rising edge.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All stimulus taken, every sum back, then a quiet tail in which any
        // stray result would be flagged by the monitor.
        @(negedge i_clk);
        while (operand_queue.size() != 0 || start || sums_done != sums_issued)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && sums_awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/far_pkg.sv
sv/far_ctrl.sv
sv/far_dp.sv
sv/fraction_add_and_reduce_top.sv
tb/fraction_add_and_reduce_top_tb.sv
